### design/hte_pkg.sv
// Package for the header table ring evictor: request and response types,
// operation codes, field widths and default limits. No dependencies.
package hte_pkg;

    // Default limits: name and value limits are handed to the top level as parameter defaults
    localparam int MAX_ENTRIES_DEF     = 64;
    localparam int MAX_NAME_BYTES_DEF  = 1023;
    localparam int MAX_VALUE_BYTES_DEF = 4095;

    // Fixed per-entry overhead added to name and value lengths
    localparam int ENTRY_OVERHEAD = 32;

    // Field widths
    localparam int NAME_W  = 10;
    localparam int VALUE_W = 12;
    localparam int CAP_W   = 16;
    localparam int COST_W  = 13;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int TOTAL_W = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INIT_CAP = 1'b0;  // register index, paddr[2]

    // Operation codes
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_SET_CAP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [NAME_W-1:0]  name_length;
        logic [VALUE_W-1:0] value_length;
        logic [CAP_W-1:0]   capacity_bytes;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] evicted_now;
        logic [CAP_W-1:0]   table_size;
        logic [COUNT_W-1:0] entry_count;
        logic [TOTAL_W-1:0] dropped_total;
    } t_rsp;

endpackage

### design/header_table_ring_evictor.sv
// Header table ring evictor: size accounting of a header-compression dynamic
// table kept as a ring of entry costs. Depends on hte_pkg and hte_ram.
//
//   Channel   Direction  Handshake                    Payload
//   request   in         i_req_valid / o_req_ready    i_req  (hte_pkg::t_req)
//   response  out        o_rsp_valid / i_rsp_ready    o_rsp  (hte_pkg::t_rsp)
//   config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// After acceptance a request passes a check step, then one eviction per cycle
// through the shared cost subtractor reading the cost RAM, then a step that
// appends the entry or settles the size, then a finish step that loads the
// response. A rejected insert goes from the check step straight to finish.
// A new request is taken once the block is back in idle; a response that
// waits holds the block in its finish cycle. Synchronous active-low reset
// empties the table and sets capacity to zero; a capacity register write
// does the same with the written value. No clearing pass is needed.
module header_table_ring_evictor #(
    parameter int MAX_NAME_BYTES  = hte_pkg::MAX_NAME_BYTES_DEF,
    parameter int MAX_VALUE_BYTES = hte_pkg::MAX_VALUE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  hte_pkg::t_req                   i_req,
    // Response channel
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output hte_pkg::t_rsp                   o_rsp,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hte_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hte_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hte_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int MAX_ENTRIES = hte_pkg::MAX_ENTRIES_DEF;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int LEN_W = 17;
    localparam int CAP_W = hte_pkg::CAP_W;
    localparam int COST_W = hte_pkg::COST_W;
    localparam int TOTAL_W = hte_pkg::TOTAL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EVICT,
        ST_FINISH
    } t_state;

    t_state              r_state, n_state;
    hte_pkg::t_req       r_req, n_req;
    hte_pkg::t_rsp       r_rsp, n_rsp;
    logic                r_rsp_valid, n_rsp_valid;
    logic [CAP_W-1:0]    r_init_cap, n_init_cap;
    logic [CAP_W-1:0]    r_capacity, n_capacity;
    logic [IDX_W-1:0]    r_oldest, n_oldest;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [CAP_W-1:0]    r_used, n_used;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [COST_W-1:0]   r_need, n_need;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0]    r_evcnt, n_evcnt;
    logic                r_accept, n_accept;

    logic                cfg_wr;
    logic [COST_W-1:0]   need_w;
    logic                reject_w;
    logic                fits_w;
    logic [SUM_W-1:0]    slot_sum;
    logic [IDX_W-1:0]    slot_w;
    logic [IDX_W-1:0]    oldest_inc;
    logic [CAP_W-1:0]    base_used;
    logic [CAP_W-1:0]    used_less;
    logic                ram_we;
    logic [COST_W-1:0]   ram_rdata;

    // Decode configuration writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hte_pkg::REG_INIT_CAP);
    assign prdata = (paddr[2] == hte_pkg::REG_INIT_CAP) ?
                    hte_pkg::APB_DATA_W'(r_init_cap) : '0;

    // Entry cost and insert checks
    assign need_w = COST_W'(r_req.name_length) + COST_W'(r_req.value_length)
                  + COST_W'(hte_pkg::ENTRY_OVERHEAD);
    assign reject_w = (LEN_W'(r_req.name_length) > LEN_W'(MAX_NAME_BYTES))
                   || (LEN_W'(r_req.value_length) > LEN_W'(MAX_VALUE_BYTES))
                   || (CAP_W'(need_w) > r_capacity)
                   || (r_held >= CNT_W'(MAX_ENTRIES));

    // Shared compare and subtract for the eviction walk
    assign fits_w = ((LEN_W'(r_used) + LEN_W'(r_need)) <= LEN_W'(r_capacity));
    assign used_less = (CAP_W'(ram_rdata) > r_used) ? '0 : (r_used - CAP_W'(ram_rdata));
    assign base_used = (r_held == '0) ? '0 : r_used;

    // Ring positions: next oldest, and slot after the newest
    assign oldest_inc = (r_oldest == IDX_W'(MAX_ENTRIES - 1)) ? '0 : (r_oldest + 1'b1);
    assign slot_sum = SUM_W'(r_oldest) + SUM_W'(r_held);
    assign slot_w = (slot_sum >= SUM_W'(MAX_ENTRIES)) ?
                    IDX_W'(slot_sum - SUM_W'(MAX_ENTRIES)) : IDX_W'(slot_sum);

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_init_cap  = r_init_cap;
        n_capacity  = r_capacity;
        n_oldest    = r_oldest;
        n_held      = r_held;
        n_used      = r_used;
        n_total     = r_total;
        n_need      = r_need;
        n_slot      = r_slot;
        n_evcnt     = r_evcnt;
        n_accept    = r_accept;
        ram_we      = 1'b0;

        // Drop a response once taken
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_slot  = '0;
                n_evcnt = '0;
                if (r_req.mode == hte_pkg::MODE_SET_CAP) begin
                    n_capacity = r_req.capacity_bytes;
                    n_need     = '0;
                    n_accept   = 1'b1;
                    n_state    = ST_EVICT;
                end else if (reject_w) begin
                    n_accept = 1'b0;
                    n_state  = ST_FINISH;
                end else begin
                    n_need   = need_w;
                    n_accept = 1'b1;
                    n_state  = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if ((r_held != '0) && !fits_w) begin
                    // Evict the oldest entry
                    n_used   = used_less;
                    n_oldest = oldest_inc;
                    n_held   = r_held - 1'b1;
                    n_total  = r_total + 1'b1;
                    n_evcnt  = r_evcnt + 1'b1;
                end else begin
                    if (r_req.mode == hte_pkg::MODE_INSERT) begin
                        // Append the new entry after the newest
                        ram_we = 1'b1;
                        n_slot = slot_w;
                        n_used = base_used + CAP_W'(r_need);
                        n_held = r_held + 1'b1;
                    end else begin
                        n_used = base_used;
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp.accepted      = r_accept;
                    n_rsp.slot_index    = hte_pkg::SLOT_W'(r_slot);
                    n_rsp.evicted_now   = hte_pkg::COUNT_W'(r_evcnt);
                    n_rsp.table_size    = r_used;
                    n_rsp.entry_count   = hte_pkg::COUNT_W'(r_held);
                    n_rsp.dropped_total = r_total;
                    n_rsp_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Capacity write re-initializes the table
        if (cfg_wr) begin
            n_init_cap = pwdata[CAP_W-1:0];
            n_capacity = pwdata[CAP_W-1:0];
            n_oldest   = '0;
            n_held     = '0;
            n_used     = '0;
            n_total    = '0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
            r_init_cap  <= '0;
            r_capacity  <= '0;
            r_oldest    <= '0;
            r_held      <= '0;
            r_used      <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_init_cap  <= n_init_cap;
            r_capacity  <= n_capacity;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_used      <= n_used;
            r_total     <= n_total;
        end
        r_req    <= n_req;
        r_rsp    <= n_rsp;
        r_need   <= n_need;
        r_slot   <= n_slot;
        r_evcnt  <= n_evcnt;
        r_accept <= n_accept;
    end

    // Entry cost ring; read follows the next oldest slot
    hte_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_ENTRIES)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_w),
        .i_wdata (r_need),
        .i_raddr (n_oldest),
        .o_rdata (ram_rdata)
    );

    // Entry count stays within the ring
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond ring depth");

    // Each eviction step drops exactly one entry
    a_evict_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT && n_state == ST_EVICT && !cfg_wr)
        |=> (r_held + CNT_W'(1) == $past(r_held)))
        else $error("eviction step did not drop one entry");

    // A response is loaded only from the finish step
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == ST_FINISH))
        else $error("response loaded outside finish");

    // An empty table holds no bytes when reported
    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_held == '0) |-> (r_used == '0))
        else $error("empty table reports nonzero size");

endmodule

### design/hte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
